// File: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/segx_pkg.sv
// Shared widths, types and helpers of the segment intersection pipeline
package segx_pkg;

  localparam int FIELD_W    = 16;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 32;

  // arithmetic widths
  localparam int AW  = COORD_BITS + 1;        // line coefficients A, B
  localparam int CCW = 2 * COORD_BITS + 2;    // coefficient C
  localparam int DW  = 2 * COORD_BITS + 3;    // determinant
  localparam int NW  = 3 * COORD_BITS + 4;    // numerators
  localparam int SW  = NW + 1;                // sign-normalised numerators
  localparam int CL  = CCW / 2;               // low split of C
  localparam int CH  = CCW - CL;
  localparam int DL  = (DW + 1) / 2;          // low split of |det|
  localparam int DH  = DW - DL;

  // divider
  localparam int QB   = OUT_W - 1;
  localparam int DVW  = (NW + FRAC_BITS > QB) ? NW + FRAC_BITS : QB + 1;
  localparam int HW   = DVW - QB;
  localparam int CMPW = (HW > DW) ? HW : DW;

  localparam int BOX_LAT = 3;
  localparam int DIV_LAT = QB + 3;
  localparam int HIT_DLY = DIV_LAT - BOX_LAT;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax_lo;
    logic signed [COORD_BITS-1:0] ax_hi;
    logic signed [COORD_BITS-1:0] ay_lo;
    logic signed [COORD_BITS-1:0] ay_hi;
    logic signed [COORD_BITS-1:0] bx_lo;
    logic signed [COORD_BITS-1:0] bx_hi;
    logic signed [COORD_BITS-1:0] by_lo;
    logic signed [COORD_BITS-1:0] by_hi;
  } segx_box_t;

  typedef struct packed {
    logic signed [SW-1:0] nx;
    logic signed [SW-1:0] ny;
    logic [DW-1:0]        den;
    logic                 zdet;
  } segx_frac_t;

  typedef struct packed {
    logic                    crossing;
    logic                    lines_par;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } segx_res_t;

  // low COORD_BITS of a field, sign-extended from the top kept bit
  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [COORD_BITS+FIELD_W-1:0] t;
    t = {{COORD_BITS{1'b0}}, f};
    return $signed(t[COORD_BITS-1:0]);
  endfunction

endpackage

// File: src/segx_coef.sv
// Front pipeline: line coefficients, determinant, numerators, sign normalisation
module segx_coef (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_a_x0_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_a_y0_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_a_x1_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_a_y1_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_b_x0_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_b_y0_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_b_x1_i,
  input  logic [segx_pkg::FIELD_W-1:0]  seg_b_y1_i,
  output logic                          vld_o,
  output segx_pkg::segx_frac_t          frac_o,
  output segx_pkg::segx_box_t           box_o
);

  localparam int CW  = segx_pkg::COORD_BITS;
  localparam int AW  = segx_pkg::AW;
  localparam int CCW = segx_pkg::CCW;
  localparam int DW  = segx_pkg::DW;
  localparam int NW  = segx_pkg::NW;
  localparam int SW  = segx_pkg::SW;
  localparam int CL  = segx_pkg::CL;
  localparam int CH  = segx_pkg::CH;
  localparam int PLW = AW + CL + 1;
  localparam int PHW = AW + CH;
  localparam int TW  = AW + CCW;

  logic signed [CW-1:0] xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1;
  segx_pkg::segx_box_t  box_d;
  segx_pkg::segx_box_t  box_q [7];
  logic [6:0]           vld_q;

  // stage 1
  logic signed [AW-1:0] a1_s1_q, b1_s1_q, a2_s1_q, b2_s1_q;
  logic signed [CW-1:0] xa_q, ya_q, xb_q, yb_q;
  // stage 2
  logic signed [CCW-2:0] pa_q, pb_q, qa_q, qb_q;
  logic signed [DW-2:0]  m1_q, m2_q;
  logic signed [AW-1:0]  a1_s2_q, b1_s2_q, a2_s2_q, b2_s2_q;
  // stage 3
  logic signed [CCW-1:0] c1_q, c2_q;
  logic signed [DW-1:0]  det3_q;
  logic signed [AW-1:0]  a1_s3_q, b1_s3_q, a2_s3_q, b2_s3_q;
  // stage 4
  logic signed [PLW-1:0] pl_b2c1_q, pl_b1c2_q, pl_a1c2_q, pl_a2c1_q;
  logic signed [PHW-1:0] ph_b2c1_q, ph_b1c2_q, ph_a1c2_q, ph_a2c1_q;
  logic signed [DW-1:0]  det4_q;
  // stage 5
  logic signed [TW-1:0]  t_b2c1_q, t_b1c2_q, t_a1c2_q, t_a2c1_q;
  logic signed [DW-1:0]  det5_q;
  // stage 6
  logic signed [NW-1:0]  nx6_q, ny6_q;
  logic signed [DW-1:0]  det6_q;
  // stage 7
  segx_pkg::segx_frac_t  frac_d, frac_q;

  logic signed [CL:0]   c1lo, c2lo;
  logic signed [CH-1:0] c1hi, c2hi;
  logic                 neg;

  assign xa0 = segx_pkg::to_coord(seg_a_x0_i);
  assign ya0 = segx_pkg::to_coord(seg_a_y0_i);
  assign xa1 = segx_pkg::to_coord(seg_a_x1_i);
  assign ya1 = segx_pkg::to_coord(seg_a_y1_i);
  assign xb0 = segx_pkg::to_coord(seg_b_x0_i);
  assign yb0 = segx_pkg::to_coord(seg_b_y0_i);
  assign xb1 = segx_pkg::to_coord(seg_b_x1_i);
  assign yb1 = segx_pkg::to_coord(seg_b_y1_i);

  // bounding boxes of both segments
  always_comb begin
    box_d.ax_lo = (xa0 < xa1) ? xa0 : xa1;
    box_d.ax_hi = (xa0 < xa1) ? xa1 : xa0;
    box_d.ay_lo = (ya0 < ya1) ? ya0 : ya1;
    box_d.ay_hi = (ya0 < ya1) ? ya1 : ya0;
    box_d.bx_lo = (xb0 < xb1) ? xb0 : xb1;
    box_d.bx_hi = (xb0 < xb1) ? xb1 : xb0;
    box_d.by_lo = (yb0 < yb1) ? yb0 : yb1;
    box_d.by_hi = (yb0 < yb1) ? yb1 : yb0;
  end

  // C split into an unsigned low part and a signed high part
  assign c1lo = $signed({1'b0, c1_q[CL-1:0]});
  assign c2lo = $signed({1'b0, c2_q[CL-1:0]});
  assign c1hi = $signed(c1_q[CCW-1:CL]);
  assign c2hi = $signed(c2_q[CCW-1:CL]);

  // sign normalisation so the denominator is positive
  assign neg = det6_q[DW-1];
  always_comb begin
    frac_d.nx   = neg ? -SW'(nx6_q) : SW'(nx6_q);
    frac_d.ny   = neg ? -SW'(ny6_q) : SW'(ny6_q);
    frac_d.den  = neg ? DW'(-det6_q) : DW'(det6_q);
    frac_d.zdet = (det6_q == '0);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q[0] <= box_d;
      for (int i = 1; i < 7; i++) begin
        box_q[i] <= box_q[i-1];
      end
      // stage 1: A and B
      a1_s1_q <= AW'(ya1) - AW'(ya0);
      b1_s1_q <= AW'(xa0) - AW'(xa1);
      a2_s1_q <= AW'(yb1) - AW'(yb0);
      b2_s1_q <= AW'(xb0) - AW'(xb1);
      xa_q    <= xa0;
      ya_q    <= ya0;
      xb_q    <= xb0;
      yb_q    <= yb0;
      // stage 2: products for C and det
      pa_q    <= a1_s1_q * xa_q;
      pb_q    <= b1_s1_q * ya_q;
      qa_q    <= a2_s1_q * xb_q;
      qb_q    <= b2_s1_q * yb_q;
      m1_q    <= a1_s1_q * b2_s1_q;
      m2_q    <= a2_s1_q * b1_s1_q;
      a1_s2_q <= a1_s1_q;
      b1_s2_q <= b1_s1_q;
      a2_s2_q <= a2_s1_q;
      b2_s2_q <= b2_s1_q;
      // stage 3: C and det
      c1_q    <= CCW'(pa_q) + CCW'(pb_q);
      c2_q    <= CCW'(qa_q) + CCW'(qb_q);
      det3_q  <= DW'(m1_q) - DW'(m2_q);
      a1_s3_q <= a1_s2_q;
      b1_s3_q <= b1_s2_q;
      a2_s3_q <= a2_s2_q;
      b2_s3_q <= b2_s2_q;
      // stage 4: partial products of the numerators
      pl_b2c1_q <= b2_s3_q * c1lo;
      ph_b2c1_q <= b2_s3_q * c1hi;
      pl_b1c2_q <= b1_s3_q * c2lo;
      ph_b1c2_q <= b1_s3_q * c2hi;
      pl_a1c2_q <= a1_s3_q * c2lo;
      ph_a1c2_q <= a1_s3_q * c2hi;
      pl_a2c1_q <= a2_s3_q * c1lo;
      ph_a2c1_q <= a2_s3_q * c1hi;
      det4_q    <= det3_q;
      // stage 5: recombine partial products
      t_b2c1_q <= (TW'(ph_b2c1_q) <<< CL) + TW'(pl_b2c1_q);
      t_b1c2_q <= (TW'(ph_b1c2_q) <<< CL) + TW'(pl_b1c2_q);
      t_a1c2_q <= (TW'(ph_a1c2_q) <<< CL) + TW'(pl_a1c2_q);
      t_a2c1_q <= (TW'(ph_a2c1_q) <<< CL) + TW'(pl_a2c1_q);
      det5_q   <= det4_q;
      // stage 6: numerators
      nx6_q  <= NW'(t_b2c1_q) - NW'(t_b1c2_q);
      ny6_q  <= NW'(t_a1c2_q) - NW'(t_a2c1_q);
      det6_q <= det5_q;
      // stage 7
      frac_q <= frac_d;
    end
  end

  assign vld_o  = vld_q[6];
  assign frac_o = frac_q;
  assign box_o  = box_q[6];

endmodule

// File: src/segx_box.sv
// Exact bounding-box test of the rational crossing point, three stages
module segx_box (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  segx_pkg::segx_frac_t frac_i,
  input  segx_pkg::segx_box_t  box_i,
  output logic                 hit_o
);

  localparam int CW = segx_pkg::COORD_BITS;
  localparam int DW = segx_pkg::DW;
  localparam int DL = segx_pkg::DL;
  localparam int DH = segx_pkg::DH;
  localparam int NW = segx_pkg::NW;
  localparam int SW = segx_pkg::SW;

  logic signed [CW-1:0]    bnd [8];
  logic signed [DL:0]      dlo;
  logic signed [DH:0]      dhi;
  logic signed [CW+DL:0]   plo_q [8];
  logic signed [CW+DH:0]   phi_q [8];
  logic signed [NW-1:0]    prod_q [8];
  logic signed [SW-1:0]    nx1_q, ny1_q, nx2_q, ny2_q;
  logic                    hit_d, hit_q;

  // even entries are lower bounds, odd upper; bit 1 selects y
  assign bnd[0] = box_i.ax_lo;
  assign bnd[1] = box_i.ax_hi;
  assign bnd[2] = box_i.ay_lo;
  assign bnd[3] = box_i.ay_hi;
  assign bnd[4] = box_i.bx_lo;
  assign bnd[5] = box_i.bx_hi;
  assign bnd[6] = box_i.by_lo;
  assign bnd[7] = box_i.by_hi;

  assign dlo = $signed({1'b0, frac_i.den[DL-1:0]});
  assign dhi = $signed({1'b0, frac_i.den[DW-1:DL]});

  // bound * den against the numerator
  always_comb begin
    hit_d = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (k[0]) begin
        hit_d = hit_d && ((k[1] ? ny2_q : nx2_q) <= SW'(prod_q[k]));
      end else begin
        hit_d = hit_d && (SW'(prod_q[k]) <= (k[1] ? ny2_q : nx2_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 8; k++) begin
        plo_q[k]  <= bnd[k] * dlo;
        phi_q[k]  <= bnd[k] * dhi;
        prod_q[k] <= (NW'(phi_q[k]) <<< DL) + NW'(plo_q[k]);
      end
      nx1_q <= frac_i.nx;
      ny1_q <= frac_i.ny;
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// File: src/segx_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating fixed-point result
module segx_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [segx_pkg::SW-1:0]    num_i,
  input  logic [segx_pkg::DW-1:0]           den_i,
  input  logic                              zdet_i,
  output logic                              vld_o,
  output logic                              zdet_o,
  output logic signed [segx_pkg::OUT_W-1:0] quo_o
);

  localparam int NW   = segx_pkg::NW;
  localparam int DW   = segx_pkg::DW;
  localparam int QB   = segx_pkg::QB;
  localparam int DVW  = segx_pkg::DVW;
  localparam int HW   = segx_pkg::HW;
  localparam int CMPW = segx_pkg::CMPW;
  localparam int OW   = segx_pkg::OUT_W;
  localparam int FB   = segx_pkg::FRAC_BITS;

  logic [QB+2:0]   vld_q;
  // entry stage
  logic [NW-1:0]   mag_q;
  logic            neg1_q, zd1_q;
  logic [DW-1:0]   den1_q;
  // quotient stages
  logic [DW-1:0]   rem_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  logic [QB-1:0]   low_q [QB+1];
  logic [DW-1:0]   den_q [QB+1];
  logic            neg_q [QB+1];
  logic            ovf_q [QB+1];
  logic            zd_q  [QB+1];
  logic [DW-1:0]   rem_n [QB+1];
  logic            qbit  [QB+1];
  // result
  logic signed [OW-1:0] res_d, res_q;
  logic                 zdo_q;

  logic [DVW-1:0]  dv;
  logic [HW-1:0]   dv_hi;
  logic            ovf;
  logic [DW:0]     trial;

  // dividend and overflow pre-check
  assign dv    = DVW'(mag_q) << FB;
  assign dv_hi = dv[DVW-1:QB];
  assign ovf   = CMPW'(dv_hi) >= CMPW'(den1_q);

  // one compare-subtract per stage
  always_comb begin
    rem_n[0] = '0;
    qbit[0]  = 1'b0;
    trial    = '0;
    for (int s = 1; s <= QB; s++) begin
      trial   = {rem_q[s-1], low_q[s-1][QB-s]};
      qbit[s] = trial >= {1'b0, den_q[s-1]};
      rem_n[s] = qbit[s] ? DW'(trial - {1'b0, den_q[s-1]}) : DW'(trial);
    end
  end

  // sign, saturation and zero determinant
  always_comb begin
    if (zd_q[QB]) begin
      res_d = '0;
    end else if (ovf_q[QB]) begin
      res_d = neg_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (neg_q[QB]) begin
      res_d = -$signed({1'b0, quo_q[QB]});
    end else begin
      res_d = $signed({1'b0, quo_q[QB]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB+1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= num_i[segx_pkg::SW-1] ? NW'(-num_i) : NW'(num_i);
      neg1_q <= num_i[segx_pkg::SW-1];
      den1_q <= den_i;
      zd1_q  <= zdet_i;
      rem_q[0] <= ovf ? '0 : DW'(dv_hi);
      quo_q[0] <= '0;
      low_q[0] <= dv[QB-1:0];
      den_q[0] <= den1_q;
      neg_q[0] <= neg1_q;
      ovf_q[0] <= ovf;
      zd_q[0]  <= zd1_q;
      for (int s = 1; s <= QB; s++) begin
        rem_q[s] <= rem_n[s];
        quo_q[s] <= {quo_q[s-1][QB-2:0], qbit[s]};
        low_q[s] <= low_q[s-1];
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        zd_q[s]  <= zd_q[s-1];
      end
      res_q <= res_d;
      zdo_q <= zd_q[QB];
    end
  end

  assign vld_o  = vld_q[QB+2];
  assign zdet_o = zdo_q;
  assign quo_o  = res_q;

endmodule

// File: src/segment_intersection.sv
// An accepted request passes the front pipeline, the divider stages and the output register in turn.
// Throughput: one request per cycle while in_stall_o is low; the quotient pipeline (one bit per stage) sets depth.
// A two-entry output register and skid stage hold results while out_stall_i is high;
// in_stall_o rises only when the skid entry is occupied.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers are not reset.
module segment_intersection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_a_x0_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_a_y0_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_a_x1_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_a_y1_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_b_x0_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_b_y0_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_b_x1_i,
  input  logic [segx_pkg::FIELD_W-1:0]      seg_b_y1_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              crossing_o,
  output logic                              lines_parallel_o,
  output logic signed [segx_pkg::OUT_W-1:0] cross_x_o,
  output logic signed [segx_pkg::OUT_W-1:0] cross_y_o
);

  localparam int HIT_DLY = segx_pkg::HIT_DLY;

  logic                  en;
  logic                  f_vld;
  segx_pkg::segx_frac_t  frac;
  segx_pkg::segx_box_t   box;
  logic                  hit;
  logic                  hit_q [HIT_DLY];
  logic                  vx, vy, zdet;
  logic signed [segx_pkg::OUT_W-1:0] qx, qy;
  logic                  pv, take;
  segx_pkg::segx_res_t   res_new, out_d, out_q, skid_d, skid_q;
  logic                  out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;

  // pipeline moves whenever the skid entry is free
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  segx_coef u_coef (
    .clk_i, .rst_ni,
    .en_i   (en),
    .vld_i  (in_valid_i),
    .seg_a_x0_i, .seg_a_y0_i, .seg_a_x1_i, .seg_a_y1_i,
    .seg_b_x0_i, .seg_b_y0_i, .seg_b_x1_i, .seg_b_y1_i,
    .vld_o  (f_vld),
    .frac_o (frac),
    .box_o  (box)
  );

  segx_box u_box (
    .clk_i,
    .en_i   (en),
    .frac_i (frac),
    .box_i  (box),
    .hit_o  (hit)
  );

  segx_div u_div_x (
    .clk_i, .rst_ni,
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (frac.nx),
    .den_i  (frac.den),
    .zdet_i (frac.zdet),
    .vld_o  (vx),
    .zdet_o (zdet),
    .quo_o  (qx)
  );

  segx_div u_div_y (
    .clk_i, .rst_ni,
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (frac.ny),
    .den_i  (frac.den),
    .zdet_i (frac.zdet),
    .vld_o  (vy),
    .zdet_o (),
    .quo_o  (qy)
  );

  // align the box test with the divider output
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q[0] <= hit;
      for (int i = 1; i < HIT_DLY; i++) begin
        hit_q[i] <= hit_q[i-1];
      end
    end
  end

  assign pv = vx && vy;
  always_comb begin
    res_new.crossing  = hit_q[HIT_DLY-1] && !zdet;
    res_new.lines_par = zdet;
    res_new.x         = qx;
    res_new.y         = qy;
  end

  // output register and skid entry
  assign take = out_vld_q && !out_stall_i;
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (take) begin
      out_vld_d  = skid_vld_q;
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end
    if (en && pv) begin
      if (!out_vld_q || take) begin
        out_vld_d = 1'b1;
        out_d     = res_new;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = res_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_vld_q;
  assign crossing_o       = out_q.crossing;
  assign lines_parallel_o = out_q.lines_par;
  assign cross_x_o        = out_q.x;
  assign cross_y_o        = out_q.y;

endmodule

// File: src/segx_chk.sv
// Port-level checker for the segment intersection block, bound to the top level
`include "assert_macros.svh"

module segx_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [segx_pkg::FIELD_W-1:0]      seg_a_x0_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_a_y0_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_a_x1_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_a_y1_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_b_x0_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_b_y0_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_b_x1_i,
  input logic [segx_pkg::FIELD_W-1:0]      seg_b_y1_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              crossing_o,
  input logic                              lines_parallel_o,
  input logic signed [segx_pkg::OUT_W-1:0] cross_x_o,
  input logic signed [segx_pkg::OUT_W-1:0] cross_y_o
);

  // a stalled result holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(cross_x_o) && $stable(cross_y_o) && $stable(crossing_o))

  // parallel lines give no crossing and a zero point
  `ASSERT_IMP(a_par_zero, clk_i, rst_ni, out_valid_o && lines_parallel_o, !crossing_o && cross_x_o == 0 && cross_y_o == 0)

  // input is only held off while a result sits stalled at the output
  `ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, $past(out_valid_o && out_stall_i))

  // skid entry occupied implies the output register is occupied
  `ASSERT_IMP(a_stall_out, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind segment_intersection segx_chk u_segx_chk (.*);
